// ----- design/utf8_to_utf16_decoder_top_assert.svh -----
// assertion macros used by the checker file
`ifndef UTF8_TO_UTF16_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_TOP_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define U8U16_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, off while reset is asserted
`define U8U16_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

// next-cycle implication that also covers reset
`define U8U16_ASSERT_RST(name, pre, post, msg) \
  name: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/u8u16_pkg.sv -----
package u8u16_pkg;

  localparam int QUEUE_DEPTH = 4;

  // sequence length classes of a first byte
  localparam logic [2:0] LEN_STRAY = 3'd0;
  localparam logic [2:0] LEN_ASCII = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  localparam logic [20:0] SURR_BASE = 21'h10000;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
  } out_item_t;

  // one queue entry: a code point, plus an optional second ascii one
  typedef struct packed {
    logic [20:0] cp0;
    logic        two;
    logic [6:0]  cp1;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) len = LEN_ASCII;
    else if ((b & 8'hE0) == 8'hC0) len = LEN_TWO;
    else if ((b & 8'hF0) == 8'hE0) len = LEN_THREE;
    else if ((b & 8'hF8) == 8'hF0) len = LEN_FOUR;
    else len = LEN_STRAY;
    return len;
  endfunction

  function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] len);
    logic [20:0] cp;
    case (len)
      LEN_TWO:   cp = {10'b0, b0[4:0], b1[5:0]};
      LEN_THREE: cp = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
      LEN_FOUR:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default:   cp = {13'b0, b0};
    endcase
    return cp;
  endfunction

endpackage

// ----- design/u8u16_fifo.sv -----
module u8u16_fifo
  import u8u16_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_data,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head         = slot_r[rd_ptr_r];
  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- design/u8u16_front.sv -----
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_data,
  output logic     push,
  output q_entry_t push_data
);

  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] len_r, len_nxt;

  logic [7:0]  b;
  logic [2:0]  blen, tlen;
  logic        complete;
  logic [20:0] full_cp;

  always_comb begin
    b        = in_data.in_byte;
    blen     = lead_length(b);
    tlen     = lead_length(held_r[1]);
    complete = (cnt_r != 2'd0) && (({1'b0, cnt_r} + 3'd1) == len_r);
    full_cp  = assemble(held_r[0], (cnt_r == 2'd1) ? b : held_r[1],
                        (cnt_r == 2'd2) ? b : held_r[2], b, len_r);

    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    push      = 1'b0;
    push_data = '0;

    if (accept) begin
      if (!in_data.in_end) begin
        if (cnt_r == 2'd0) begin
          if (blen == LEN_ASCII) begin
            push          = 1'b1;
            push_data.cp0 = {13'b0, b};
          end else if (blen != LEN_STRAY) begin
            held_nxt[0] = b;
            cnt_nxt     = 2'd1;
            len_nxt     = blen;
          end
        end else if (complete) begin
          push          = 1'b1;
          push_data.cp0 = full_cp;
          cnt_nxt       = 2'd0;
          len_nxt       = LEN_STRAY;
        end else begin
          case (cnt_r)
            2'd1:    held_nxt[1] = b;
            2'd2:    held_nxt[2] = b;
            default: ;
          endcase
          cnt_nxt = cnt_r + 2'd1;
        end
      end else begin
        // end of text: clear the held bytes, emitting what still decodes
        cnt_nxt = 2'd0;
        len_nxt = LEN_STRAY;
        if (cnt_r inside {2'd0, 2'd1}) begin
          if (cnt_r == 2'd0 && blen == LEN_ASCII) begin
            push          = 1'b1;
            push_data.cp0 = {13'b0, b};
          end else if (complete) begin
            push          = 1'b1;
            push_data.cp0 = full_cp;
          end else if (blen == LEN_ASCII && cnt_r == 2'd1) begin
            push          = 1'b1;
            push_data.cp0 = {13'b0, b};
          end
        end else if (complete) begin
          push          = 1'b1;
          push_data.cp0 = full_cp;
        end else begin
          // lead dropped, the held byte after it and this byte decoded again
          if (tlen == LEN_ASCII) begin
            push          = 1'b1;
            push_data.cp0 = {13'b0, held_r[1]};
            push_data.two = (blen == LEN_ASCII);
            push_data.cp1 = b[6:0];
          end else if (tlen == LEN_TWO) begin
            push          = 1'b1;
            push_data.cp0 = assemble(held_r[1], b, b, b, LEN_TWO);
          end else if (blen == LEN_ASCII) begin
            push          = 1'b1;
            push_data.cp0 = {13'b0, b};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      len_r <= LEN_STRAY;
    end else begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

// ----- design/u8u16_back.sv -----
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_entry_t  head,
  input  q_status_t status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [1:0] {PH_FIRST, PH_LOW, PH_EXTRA} phase_t;

  phase_t      phase_r, phase_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        load, surr, last;
  logic [20:0] v;
  logic [15:0] unit;

  always_comb begin
    load = !status.empty && (!out_valid_r || !out_stall);
    surr = |head.cp0[20:16];
    v    = head.cp0 - SURR_BASE;
    case (phase_r)
      PH_FIRST: begin
        unit      = surr ? (HI_SURR | {5'b0, v[20:10]}) : head.cp0[15:0];
        last      = !surr && !head.two;
        phase_nxt = surr ? PH_LOW : PH_EXTRA;
      end
      PH_LOW: begin
        unit      = LO_SURR | {6'b0, v[9:0]};
        last      = !head.two;
        phase_nxt = PH_EXTRA;
      end
      PH_EXTRA: begin
        unit      = {9'b0, head.cp1};
        last      = 1'b1;
        phase_nxt = PH_FIRST;
      end
      default: begin
        unit      = '0;
        last      = 1'b1;
        phase_nxt = PH_FIRST;
      end
    endcase
    pop = load && last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= PH_FIRST;
    end else begin
      if (load) begin
        out_valid_r         <= 1'b1;
        out_data_r.code_unit <= unit;
        out_data_r.run_last  <= last;
        phase_r             <= last ? PH_FIRST : phase_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/utf8_to_utf16_decoder_top.sv -----
// utf-8 to utf-16 stream decoder. one byte transaction is taken per cycle while
// the entry queue has room; a byte that completes a code point of up to 0xFFFF, or an
// ascii byte outside a sequence, gives one code unit, a code point above 0xFFFF gives
// a surrogate pair (high half first) and an end-of-text byte can flush up to two
// units. the back end takes code points from the entry queue and sends one code unit
// per cycle from its output register while out_stall is low; no run of bytes yields
// more units than it has bytes, so with the output free the input never waits and
// the rate stays one byte per cycle. the QUEUE_DEPTH_P entry queue between the
// classifier and the unit emitter absorbs output stalls; in_stall rises only once it
// is full. run_last marks the final unit caused by one input byte; bytes that only
// open or extend a sequence, and stray bytes, give no output at all.
module utf8_to_utf16_decoder_top
  import u8u16_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // front to queue
  logic      push;
  q_entry_t  push_data;

  // queue to back
  q_entry_t  head;
  q_status_t status;
  logic      pop;

  logic      accept;

  // stall on a full queue only, so bytes keep flowing while the output waits
  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  // classifier: holds partial sequences, builds code points
  u8u16_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  // short queue decoupling the two halves
  u8u16_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  // emitter: splits code points into units, one per cycle while out_stall is low
  u8u16_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/u8u16_checker.sv -----
`include "utf8_to_utf16_decoder_top_assert.svh"

module u8u16_checker
  import u8u16_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic mid_group;

  // a unit taken that is not the last of its group
  assign mid_group = out_valid && !out_stall && !out_data.run_last;

  // output register is cleared by reset
  `U8U16_ASSERT_RST(a_rst_clears_out, !rst_n, !out_valid, "out_valid after reset")

  // the queue is empty after reset, so input is not stalled
  `U8U16_ASSERT_RST(a_rst_in_ready, !rst_n, !in_stall, "in_stall after reset")

  // the rest of a multi-unit transaction group follows without a gap
  `U8U16_ASSERT_NEXT(a_group_no_gap, mid_group, out_valid, "gap inside a unit group")

  // a stalled result transaction stays
  `U8U16_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped under stall")

  `U8U16_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "out_data changed under stall")

endmodule

bind utf8_to_utf16_decoder_top u8u16_checker u_chk (.*);
